/* rtl/mp3_frame_chain_walker_macros.svh */
// ----------------------------------------------------------------------------
// mp3_frame_chain_walker_macros.svh
// Assertion macros for the frame chain walker RTL.
// ----------------------------------------------------------------------------
`ifndef MP3_FRAME_CHAIN_WALKER_MACROS_SVH
`define MP3_FRAME_CHAIN_WALKER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MP3FCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MP3FCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mp3fcw_pkg.sv */
// ----------------------------------------------------------------------------
// mp3fcw_pkg
// Widths, header codes, rate tables and shared types of the frame chain walker.
// ----------------------------------------------------------------------------
`default_nettype none

package mp3fcw_pkg;

  localparam int unsigned MAX_FILE_BYTES = 262144;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 19;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned KBPS_W  = 9;
  localparam int unsigned HZ_W    = 16;
  localparam int unsigned DUR_W   = 20;
  localparam int unsigned FMS_W   = 8;   // per-frame ms, at most 72
  localparam int unsigned QUO_W   = 11;  // frame size before padding, at most 1440
  localparam int unsigned SIZE_W  = QUO_W + 1;
  localparam int unsigned DEN_W   = HZ_W;
  localparam int unsigned NUM_W   = DEN_W + QUO_W - 1;
  localparam int unsigned SCALE_W = 18;
  localparam int unsigned DCNT_W  = $clog2(QUO_W);

  localparam logic [CNT_W-1:0] FRAMES_MAX = '1;
  localparam logic [DUR_W-1:0] MS_MAX     = '1;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC_MASK = 8'hE0;

  localparam logic [1:0] VER_MPEG25   = 2'd0;
  localparam logic [1:0] VER_RESERVED = 2'd1;
  localparam logic [1:0] VER_MPEG2    = 2'd2;
  localparam logic [1:0] VER_MPEG1    = 2'd3;
  localparam logic [1:0] LAYER_III    = 2'd1;

  // samples/8 * 1000
  localparam logic [SCALE_W-1:0] SCALE_V1 = 18'd144000;
  localparam logic [SCALE_W-1:0] SCALE_V2 = 18'd72000;

  localparam logic [SIZE_W-1:0] MIN_FRAME = 12'd4;

  typedef struct packed {
    logic              ok;
    logic              v1;
    logic              pad;
    logic [KBPS_W-1:0] kbps;
    logic [HZ_W-1:0]   hz;
    logic [FMS_W-1:0]  ms;
  } hdr_info_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_stat_t;

  function automatic logic [KBPS_W-1:0] kbps_lut(input logic v1, input logic [3:0] idx);
    logic [KBPS_W-1:0] k;
    if (v1) begin
      case (idx)
        4'd1:    k = 9'd32;
        4'd2:    k = 9'd40;
        4'd3:    k = 9'd48;
        4'd4:    k = 9'd56;
        4'd5:    k = 9'd64;
        4'd6:    k = 9'd80;
        4'd7:    k = 9'd96;
        4'd8:    k = 9'd112;
        4'd9:    k = 9'd128;
        4'd10:   k = 9'd160;
        4'd11:   k = 9'd192;
        4'd12:   k = 9'd224;
        4'd13:   k = 9'd256;
        4'd14:   k = 9'd320;
        default: k = '0;
      endcase
    end else begin
      case (idx)
        4'd1:    k = 9'd8;
        4'd2:    k = 9'd16;
        4'd3:    k = 9'd24;
        4'd4:    k = 9'd32;
        4'd5:    k = 9'd40;
        4'd6:    k = 9'd48;
        4'd7:    k = 9'd56;
        4'd8:    k = 9'd64;
        4'd9:    k = 9'd80;
        4'd10:   k = 9'd96;
        4'd11:   k = 9'd112;
        4'd12:   k = 9'd128;
        4'd13:   k = 9'd144;
        4'd14:   k = 9'd160;
        default: k = '0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [HZ_W-1:0] hz_lut(input logic [1:0] ver, input logic [1:0] idx);
    logic [HZ_W-1:0] h;
    h = '0;
    case (ver)
      VER_MPEG1: begin
        case (idx)
          2'd0:    h = 16'd44100;
          2'd1:    h = 16'd48000;
          2'd2:    h = 16'd32000;
          default: h = '0;
        endcase
      end
      VER_MPEG2: begin
        case (idx)
          2'd0:    h = 16'd22050;
          2'd1:    h = 16'd24000;
          2'd2:    h = 16'd16000;
          default: h = '0;
        endcase
      end
      VER_MPEG25: begin
        case (idx)
          2'd0:    h = 16'd11025;
          2'd1:    h = 16'd12000;
          2'd2:    h = 16'd8000;
          default: h = '0;
        endcase
      end
      default: h = '0;
    endcase
    return h;
  endfunction

  // integer ms of one frame: samples * 1000 / rate
  function automatic logic [FMS_W-1:0] ms_lut(input logic [1:0] ver, input logic [1:0] idx);
    logic [FMS_W-1:0] m;
    m = '0;
    case (ver)
      VER_MPEG1, VER_MPEG2: begin
        case (idx)
          2'd0:    m = 8'd26;
          2'd1:    m = 8'd24;
          2'd2:    m = 8'd36;
          default: m = '0;
        endcase
      end
      VER_MPEG25: begin
        case (idx)
          2'd0:    m = 8'd52;
          2'd1:    m = 8'd48;
          2'd2:    m = 8'd72;
          default: m = '0;
        endcase
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/mp3fcw_in_if.sv */
// ----------------------------------------------------------------------------
// mp3fcw_in_if
// Byte channel into the walker: valid/ready with one file byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mp3fcw_in_if;
  logic                            valid;
  logic                            ready;
  logic [mp3fcw_pkg::BYTE_W-1:0]   byte_value;
  logic                            last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/mp3fcw_out_if.sv */
// ----------------------------------------------------------------------------
// mp3fcw_out_if
// Report channel out of the walker: one item per file.
// ----------------------------------------------------------------------------
`default_nettype none

interface mp3fcw_out_if;
  logic                            valid;
  logic                            ready;
  logic [mp3fcw_pkg::CNT_W-1:0]    frame_count;
  logic [mp3fcw_pkg::KBPS_W-1:0]   first_bitrate_kbps;
  logic [mp3fcw_pkg::HZ_W-1:0]     first_rate_hz;
  logic [mp3fcw_pkg::DUR_W-1:0]    total_ms;
  logic [mp3fcw_pkg::POS_W-1:0]    stop_offset;
  logic                            chain_complete;

  modport source (output valid, output frame_count, output first_bitrate_kbps,
                  output first_rate_hz, output total_ms, output stop_offset,
                  output chain_complete, input ready);
  modport sink   (input valid, input frame_count, input first_bitrate_kbps,
                  input first_rate_hz, input total_ms, input stop_offset,
                  input chain_complete, output ready);
endinterface

`default_nettype wire

/* rtl/mp3_frame_chain_walker.sv */
// Flow: a byte that does not complete an expected header is taken at once; the fourth
// header byte starts the divider, and the next byte is taken only after the divider loads,
// produces its quotient bits one per cycle and signals done, and UPD applies the frame. A report
// is presented in the cycle after the last byte is taken or, when that byte closed a header, once
// RPT finds the output slot free. One byte per cycle between headers while the report slot is free.
// Reset: synchronous, active low; clears the walk, the sequencer and the report slot's valid flag.
// ----------------------------------------------------------------------------
// mp3_frame_chain_walker
// Walks the chain of Layer III frame headers through one MP3 file and reports
// frame count, first rate and bitrate, total duration and stop offset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mp3_frame_chain_walker_macros.svh"

module mp3_frame_chain_walker (
  input  logic             clk,
  input  logic             rst_n,
  mp3fcw_in_if.sink        in_if,
  mp3fcw_out_if.source     out_if
);

  // sequencer: IDLE takes bytes, DIV waits on the divider, UPD applies the
  // frame, RPT holds a pending report until the output slot frees up
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_RPT  = 4'b1000
  } state_t;

  state_t state_r;

  // walk state
  logic [mp3fcw_pkg::POS_W-1:0]    bp_r;      // bytes taken in this file, up to the size limit
  logic [mp3fcw_pkg::POS_W-1:0]    nfo_r;     // expected next frame start
  logic [3*mp3fcw_pkg::BYTE_W-1:0] hs_r;      // last three bytes
  logic                            stopped_r;
  logic [mp3fcw_pkg::CNT_W-1:0]    frames_r;
  logic [mp3fcw_pkg::DUR_W-1:0]    dur_r;
  logic [mp3fcw_pkg::HZ_W-1:0]     first_hz_r;
  logic [mp3fcw_pkg::KBPS_W-1:0]   first_kbps_r;
  logic                            last_pend_r;

  // header held across the divide
  logic [mp3fcw_pkg::KBPS_W-1:0]   kbps_r;
  logic [mp3fcw_pkg::HZ_W-1:0]     hz_r;
  logic [mp3fcw_pkg::FMS_W-1:0]    ms_r;
  logic                            pad_r;

  // report slot
  logic                            out_valid_r;
  logic [mp3fcw_pkg::CNT_W-1:0]    o_frames_r;
  logic [mp3fcw_pkg::KBPS_W-1:0]   o_kbps_r;
  logic [mp3fcw_pkg::HZ_W-1:0]     o_hz_r;
  logic [mp3fcw_pkg::DUR_W-1:0]    o_dur_r;
  logic [mp3fcw_pkg::POS_W-1:0]    o_stop_r;
  logic                            o_done_r;

  mp3fcw_pkg::hdr_info_t hdr;
  mp3fcw_pkg::div_ctrl_t div_ctrl;
  mp3fcw_pkg::div_stat_t div_stat;

  logic                                          in_acc;
  logic                                          out_free;
  logic                                          in_range;
  logic                                          at_hdr;
  logic                                          eval;
  logic [mp3fcw_pkg::POS_W-1:0]                  bp_nxt;
  logic                                          report;
  logic [mp3fcw_pkg::KBPS_W+mp3fcw_pkg::SCALE_W-1:0] prod;
  logic [mp3fcw_pkg::SIZE_W-1:0]                 size;
  logic                                          size_ok;
  logic [mp3fcw_pkg::DUR_W:0]                    dur_sum;

  mp3fcw_hdr u_hdr (
    .hdr  (hs_r),
    .info (hdr)
  );

  mp3fcw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .stat  (div_stat)
  );

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc      = in_if.valid && in_if.ready;

  // bytes past the size limit are dropped from the walk
  assign in_range = (bp_r < mp3fcw_pkg::POS_W'(mp3fcw_pkg::MAX_FILE_BYTES));
  // the fourth header byte arrives: the other three sit in hs_r
  assign at_hdr   = ({1'b0, bp_r} == ({1'b0, nfo_r} + (mp3fcw_pkg::POS_W+1)'(3)));
  assign eval     = in_range && !stopped_r && at_hdr;
  assign bp_nxt   = (in_acc && in_range) ? bp_r + 1'b1 : bp_r;

  // frame bytes times rate = 1000 * samples/8 * kbps
  assign prod = hdr.kbps * (hdr.v1 ? mp3fcw_pkg::SCALE_V1 : mp3fcw_pkg::SCALE_V2);

  assign div_ctrl.start = (state_r == ST_IDLE) && in_acc && eval && hdr.ok;
  assign div_ctrl.num   = prod[mp3fcw_pkg::NUM_W-1:0];
  assign div_ctrl.den   = hdr.hz;

  assign size    = {1'b0, div_stat.quo} + mp3fcw_pkg::SIZE_W'(pad_r);
  assign size_ok = (size >= mp3fcw_pkg::MIN_FRAME);
  assign dur_sum = {1'b0, dur_r} + (mp3fcw_pkg::DUR_W+1)'(ms_r);

  // report either straight on the last byte or once its header is done
  assign report = ((state_r == ST_IDLE) && in_acc && in_if.last_byte && !div_ctrl.start) ||
                  ((state_r == ST_RPT) && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bp_r         <= '0;
      nfo_r        <= '0;
      hs_r         <= '0;
      stopped_r    <= 1'b0;
      frames_r     <= '0;
      dur_r        <= '0;
      first_hz_r   <= '0;
      first_kbps_r <= '0;
      last_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_range) begin
              hs_r <= {hs_r[2*mp3fcw_pkg::BYTE_W-1:0], in_if.byte_value};
              bp_r <= bp_nxt;
            end
            if (eval) begin
              if (hdr.ok) begin
                last_pend_r <= in_if.last_byte;
                state_r     <= ST_DIV;
              end else begin
                stopped_r <= 1'b1;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (size_ok) begin
            if (frames_r == '0) begin
              first_hz_r   <= hz_r;
              first_kbps_r <= kbps_r;
            end
            if (frames_r != mp3fcw_pkg::FRAMES_MAX) begin
              frames_r <= frames_r + 1'b1;
            end
            dur_r <= (dur_sum > {1'b0, mp3fcw_pkg::MS_MAX}) ? mp3fcw_pkg::MS_MAX
                                                              : dur_sum[mp3fcw_pkg::DUR_W-1:0];
            nfo_r <= nfo_r + mp3fcw_pkg::POS_W'(size);
          end else begin
            stopped_r <= 1'b1;
          end
          state_r <= last_pend_r ? ST_RPT : ST_IDLE;
        end
        ST_RPT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // end of file: hand off totals, start the next file from scratch
      if (report) begin
        out_valid_r  <= 1'b1;
        bp_r         <= '0;
        nfo_r        <= '0;
        hs_r         <= '0;
        stopped_r    <= 1'b0;
        frames_r     <= '0;
        dur_r        <= '0;
        first_hz_r   <= '0;
        first_kbps_r <= '0;
        last_pend_r  <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (div_ctrl.start) begin
      kbps_r <= hdr.kbps;
      hz_r   <= hdr.hz;
      ms_r   <= hdr.ms;
      pad_r  <= hdr.pad;
    end
    if (report) begin
      o_frames_r <= frames_r;
      o_kbps_r   <= first_kbps_r;
      o_hz_r     <= first_hz_r;
      o_dur_r    <= dur_r;
      o_stop_r   <= nfo_r;
      o_done_r   <= (nfo_r >= bp_nxt);
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.frame_count        = o_frames_r;
  assign out_if.first_bitrate_kbps = o_kbps_r;
  assign out_if.first_rate_hz      = o_hz_r;
  assign out_if.total_ms           = o_dur_r;
  assign out_if.stop_offset        = o_stop_r;
  assign out_if.chain_complete     = o_done_r;

  `MP3FCW_ASSERT_IMP(a_start_idle, div_ctrl.start, !div_stat.busy, "divider restarted while busy")
  `MP3FCW_ASSERT_IMP(a_done_in_div, div_stat.done, state_r == ST_DIV, "divider done outside DIV")
  `MP3FCW_ASSERT_NXT(a_div_to_upd, (state_r == ST_DIV) && div_stat.done, state_r == ST_UPD, "no update after divide")
  `MP3FCW_ASSERT_IMP(a_rpt_pending, state_r == ST_RPT, last_pend_r, "report state without a last byte")
  `MP3FCW_ASSERT_IMP(a_upd_live, state_r == ST_UPD, !stopped_r, "frame update on a stopped walk")

endmodule

`default_nettype wire

/* rtl/mp3fcw_hdr.sv */
// ----------------------------------------------------------------------------
// mp3fcw_hdr
// Decodes the first three header bytes: sync, version, layer, rate lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3fcw_hdr (
  input  logic [3*mp3fcw_pkg::BYTE_W-1:0] hdr,
  output mp3fcw_pkg::hdr_info_t           info
);

  logic [mp3fcw_pkg::BYTE_W-1:0] b0;
  logic [mp3fcw_pkg::BYTE_W-1:0] b1;
  logic [mp3fcw_pkg::BYTE_W-1:0] b2;
  logic [1:0]                    ver;
  logic [1:0]                    layer;
  logic                          sync_ok;
  logic                          kind_ok;

  assign b0    = hdr[23:16];
  assign b1    = hdr[15:8];
  assign b2    = hdr[7:0];
  assign ver   = b1[4:3];
  assign layer = b1[2:1];

  assign sync_ok = (b0 == mp3fcw_pkg::SYNC_BYTE) &&
                   ((b1 & mp3fcw_pkg::SYNC_MASK) == mp3fcw_pkg::SYNC_MASK);
  assign kind_ok = (ver != mp3fcw_pkg::VER_RESERVED) && (layer == mp3fcw_pkg::LAYER_III);

  always_comb begin
    info.v1   = (ver == mp3fcw_pkg::VER_MPEG1);
    info.pad  = b2[1];
    info.kbps = mp3fcw_pkg::kbps_lut(info.v1, b2[7:4]);
    info.hz   = mp3fcw_pkg::hz_lut(ver, b2[3:2]);
    info.ms   = mp3fcw_pkg::ms_lut(ver, b2[3:2]);
    info.ok   = sync_ok && kind_ok && (info.kbps != '0) && (info.hz != '0);
  end

endmodule

`default_nettype wire

/* rtl/mp3fcw_div.sv */
// ----------------------------------------------------------------------------
// mp3fcw_div
// Restoring divider, one quotient bit per cycle, for the frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3fcw_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mp3fcw_pkg::div_ctrl_t ctrl,
  output mp3fcw_pkg::div_stat_t stat
);

  logic [mp3fcw_pkg::NUM_W-1:0]  rem_r;
  logic [mp3fcw_pkg::NUM_W-1:0]  dsh_r;
  logic [mp3fcw_pkg::QUO_W-1:0]  quo_r;
  logic [mp3fcw_pkg::DCNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic                          fits;

  assign fits = (rem_r >= dsh_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= mp3fcw_pkg::DCNT_W'(mp3fcw_pkg::QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: divisor starts aligned to the top quotient bit
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r <= ctrl.num;
      dsh_r <= {ctrl.den, (mp3fcw_pkg::QUO_W-1)'(0)};
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[mp3fcw_pkg::QUO_W-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quo  = quo_r;

endmodule

`default_nettype wire
